// File: design/two_queue_priority_credit_sender_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-queue priority credit sender
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef TWO_QUEUE_PRIORITY_CREDIT_SENDER_DEFINES_SVH
`define TWO_QUEUE_PRIORITY_CREDIT_SENDER_DEFINES_SVH

// Implication checked in the same cycle as the antecedent.
`define TQPCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tqpcs: same-cycle check failed");

// Implication checked in the cycle after the antecedent.
`define TQPCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tqpcs: next-cycle check failed");

`endif

// File: design/tqpcs_pkg.sv
// ---------------------------------------------------------------------------
// Package for the two-queue priority credit sender
// Sizes, command and status codes, and queue pointer type.
// ---------------------------------------------------------------------------
package tqpcs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TAG_BITS    = 16;

  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] WIRE_LIMIT_RESET = 8'd4;

  typedef enum logic [2:0] {
    CMD_POST      = 3'd0,
    CMD_DEQUEUE   = 3'd1,
    CMD_SEND_FAIL = 3'd2,
    CMD_RETIRE    = 3'd3,
    CMD_FLUSH     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_THROTTLED = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [QPTR_W-1:0] head;
    logic [QCNT_W-1:0] fill;
  } fifo_ptr_t;

endpackage

// File: design/two_queue_priority_credit_sender.sv
// ---------------------------------------------------------------------------
// Two-queue strict-priority sender with a credit window
// Order: a command is captured in the input register, and its result (done_o) appears once
// the result register has loaded it.
// Throughput: one command per cycle; busy_o stays low, the receiver cannot stall.
// Reset (rst_ni low, asynchronous): queues empty, all counters zero, wire limit 4.
// ---------------------------------------------------------------------------
// Structure: an input register captures each command transfer; one pass of
// short logic then updates both FIFOs and the counters and loads the result
// register. The counter outputs come straight from the state registers, which
// hold the value after the command whose result is on the ports.
module two_queue_priority_credit_sender
  import tqpcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // command transfer
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] msg_tag_i,
  input  logic        needs_reply_i,
  // wire limit register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // result transfer
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] sent_tag_o,
  output logic        sent_needs_reply_o,
  output logic        idle_pulse_o,
  output logic [7:0]  in_flight_o,
  output logic [15:0] pending_total_o,
  output logic [31:0] unicast_total_o,
  output logic [31:0] sent_total_o
);

  // Input register
  logic        valid_q;
  logic [2:0]  cmd_q;
  logic [15:0] tag_q;
  logic        reply_q;

  // Queue storage and pointers
  logic [TAG_BITS-1:0] prio_mem_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] req_mem_q  [QUEUE_DEPTH];
  fifo_ptr_t prio_q, prio_d;
  fifo_ptr_t req_q, req_d;

  // Counters and configuration
  logic [7:0]  wire_limit_q;
  logic [7:0]  wire_q, wire_d;
  logic [15:0] outst_q, outst_d;
  logic [31:0] uni_q, uni_d;
  logic [31:0] sent_q, sent_d;

  // Result register
  logic        done_q;
  status_e     status_q, status_d;
  logic [15:0] sent_tag_q, sent_tag_d;
  logic        sent_reply_q, sent_reply_d;
  logic        pulse_q, pulse_d;

  // Datapath helpers
  logic                prio_push, req_push;
  logic [QPTR_W-1:0]   prio_slot, req_slot;
  logic [TAG_BITS-1:0] tag_store;
  logic [31:0]         tag_wide;
  logic [31:0]         pop_wide;
  logic                drop_en;
  logic [15:0]         drop_n;

  // Slot after the last filled entry, wrapping at the queue depth.
  function automatic logic [QPTR_W-1:0] tail_slot(fifo_ptr_t p);
    logic [QCNT_W:0] sum;
    sum = (QCNT_W + 1)'(p.head) + (QCNT_W + 1)'(p.fill);
    if (sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (QCNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[QPTR_W-1:0];
  endfunction

  function automatic logic [QPTR_W-1:0] head_next(logic [QPTR_W-1:0] h);
    return (h == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  assign busy_o    = 1'b0;
  assign tag_wide  = 32'(tag_q);
  assign tag_store = tag_wide[TAG_BITS-1:0];
  assign prio_slot = tail_slot(prio_q);
  assign req_slot  = tail_slot(req_q);

  // Capture each command transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q   <= cmd_i;
      tag_q   <= msg_tag_i;
      reply_q <= needs_reply_i;
    end
  end

  // Command decode and state update.
  always_comb begin
    prio_d       = prio_q;
    req_d        = req_q;
    wire_d       = wire_q;
    uni_d        = uni_q;
    sent_d       = sent_q;
    status_d     = STATUS_OK;
    sent_tag_d   = '0;
    sent_reply_d = 1'b0;
    prio_push    = 1'b0;
    req_push     = 1'b0;
    drop_en      = 1'b0;
    drop_n       = 16'd1;
    pop_wide     = '0;

    if (valid_q) begin
      case (cmd_e'(cmd_q))
        CMD_POST: begin
          if (reply_q) begin
            if (req_q.fill >= QCNT_W'(QUEUE_DEPTH)) begin
              status_d = STATUS_FULL;
            end else begin
              req_push   = 1'b1;
              req_d.fill = req_q.fill + 1'b1;
            end
          end else if (prio_q.fill >= QCNT_W'(QUEUE_DEPTH)) begin
            status_d = STATUS_FULL;
          end else begin
            prio_push   = 1'b1;
            prio_d.fill = prio_q.fill + 1'b1;
          end
        end
        CMD_DEQUEUE: begin
          // Throttle takes precedence over emptiness.
          if (wire_q >= wire_limit_q) begin
            status_d = STATUS_THROTTLED;
          end else if (prio_q.fill != '0) begin
            pop_wide    = 32'(prio_mem_q[prio_q.head]);
            sent_tag_d  = pop_wide[15:0];
            prio_d.head = head_next(prio_q.head);
            prio_d.fill = prio_q.fill - 1'b1;
            uni_d       = (uni_q != '1) ? uni_q + 1'b1 : uni_q;
            sent_d      = (sent_q != '1) ? sent_q + 1'b1 : sent_q;
          end else if (req_q.fill != '0) begin
            pop_wide     = 32'(req_mem_q[req_q.head]);
            sent_tag_d   = pop_wide[15:0];
            sent_reply_d = 1'b1;
            req_d.head   = head_next(req_q.head);
            req_d.fill   = req_q.fill - 1'b1;
            wire_d       = (wire_q != '1) ? wire_q + 1'b1 : wire_q;
            sent_d       = (sent_q != '1) ? sent_q + 1'b1 : sent_q;
          end else begin
            status_d = STATUS_EMPTY;
          end
        end
        CMD_SEND_FAIL: begin
          // Unicast count is left as it is.
          sent_d = (sent_q != '0) ? sent_q - 1'b1 : sent_q;
          if (reply_q) begin
            wire_d  = (wire_q != '0) ? wire_q - 1'b1 : wire_q;
            drop_en = 1'b1;
          end
        end
        CMD_RETIRE: begin
          wire_d  = (wire_q != '0) ? wire_q - 1'b1 : wire_q;
          drop_en = 1'b1;
        end
        CMD_FLUSH: begin
          drop_en = 1'b1;
          drop_n  = 16'(req_q.fill);
          prio_d  = '0;
          req_d   = '0;
        end
        default: begin
          // unused codes: no effect, status ok
        end
      endcase
    end
  end

  // Outstanding count rises on a reply post and drops, both with saturation; pulse on nonzero to zero.
  always_comb begin
    outst_d = outst_q;
    pulse_d = 1'b0;
    if (valid_q && cmd_e'(cmd_q) == CMD_POST && req_push) begin
      outst_d = (outst_q != '1) ? outst_q + 1'b1 : outst_q;
    end else if (drop_en) begin
      outst_d = (drop_n >= outst_q) ? '0 : outst_q - drop_n;
      pulse_d = (outst_q != '0) && (outst_d == '0);
    end
  end

  // Queue storage: write on a successful post only.
  always_ff @(posedge clk_i) begin
    if (prio_push) begin
      prio_mem_q[prio_slot] <= tag_store;
    end
    if (req_push) begin
      req_mem_q[req_slot] <= tag_store;
    end
  end

  // Control state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q       <= '0;
      req_q        <= '0;
      wire_q       <= '0;
      outst_q      <= '0;
      uni_q        <= '0;
      sent_q       <= '0;
      wire_limit_q <= WIRE_LIMIT_RESET;
      done_q       <= 1'b0;
    end else begin
      prio_q  <= prio_d;
      req_q   <= req_d;
      wire_q  <= wire_d;
      outst_q <= outst_d;
      uni_q   <= uni_d;
      sent_q  <= sent_d;
      done_q  <= valid_q;
      if (cfg_we_i) begin
        wire_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload: load with each processed command, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      status_q     <= status_d;
      sent_tag_q   <= sent_tag_d;
      sent_reply_q <= sent_reply_d;
      pulse_q      <= pulse_d;
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign sent_tag_o         = sent_tag_q;
  assign sent_needs_reply_o = sent_reply_q;
  assign idle_pulse_o       = pulse_q;
  assign in_flight_o        = wire_q;
  assign pending_total_o    = outst_q;
  assign unicast_total_o    = uni_q;
  assign sent_total_o       = sent_q;

endmodule

// File: design/tqpcs_checker.sv
// ---------------------------------------------------------------------------
// Port checker for the two-queue priority credit sender
// Watches command and result transfers on the top-level ports.
// ---------------------------------------------------------------------------
`include "two_queue_priority_credit_sender_defines.svh"

module tqpcs_checker
  import tqpcs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic        sent_needs_reply_o,
  input logic        idle_pulse_o,
  input logic [15:0] pending_total_o
);

  logic take;
  assign take = start_i && !busy_o;

  // every transfer gives one result via the input and result registers, and none appears unasked
  `TQPCS_ASSERT_NXT(a_result_follows, clk_i, rst_ni, take, ##1 done_o)
  `TQPCS_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, done_o, $past(take && rst_ni, 2))
  // a reply-expecting send is only reported on a successful dequeue
  `TQPCS_ASSERT_IMP(a_reply_ok, clk_i, rst_ni, done_o && sent_needs_reply_o,
                    status_o == STATUS_OK)
  // the idle pulse means the outstanding count stands at zero
  `TQPCS_ASSERT_IMP(a_idle_zero, clk_i, rst_ni, done_o && idle_pulse_o,
                    pending_total_o == 16'd0)

endmodule

bind two_queue_priority_credit_sender tqpcs_checker u_tqpcs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_o             (busy_o),
  .done_o             (done_o),
  .status_o           (status_o),
  .sent_needs_reply_o (sent_needs_reply_o),
  .idle_pulse_o       (idle_pulse_o),
  .pending_total_o    (pending_total_o)
);
